// ===== rtl/plfq_pkg.sv =====
// Package with the types, codes and helper functions of the particle lifetime fade queue.
package plfq_pkg;

    localparam int PLFQ_DEPTH     = 16;
    localparam int PLFQ_DIV_STEPS = 8;
    localparam int POS_W          = 20;
    localparam int LIFE_W         = 16;
    localparam int RGB_W          = 24;
    localparam int SIZE_W         = 10;
    localparam int CFG_W          = 24;

    localparam logic [LIFE_W-1:0] RST_FULL_LIFETIME = 16'd600;
    localparam logic [RGB_W-1:0]  RST_PARTICLE_RGB  = 24'hFFFFFF;
    localparam logic [SIZE_W-1:0] RST_SPRITE_SIZE   = 10'd16;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_DRAW = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        REG_FULL_LIFETIME = 2'd0,
        REG_PARTICLE_RGB  = 2'd1,
        REG_SPRITE_WIDTH  = 2'd2,
        REG_SPRITE_HEIGHT = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_DRAW
    } t_state;

    typedef struct packed {
        logic rot;
        logic dec;
    } t_cell_ctl;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              sat;
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  top;
        logic [POS_W-1:0]  right;
        logic [POS_W-1:0]  bottom;
        logic [LIFE_W-1:0] rem;
        logic [7:0]        lo;
        logic [7:0]        q;
    } t_quad;

    // Clamps a 22-bit signed sum to the signed 20-bit range.
    function automatic logic [POS_W-1:0] sat20(input logic [POS_W+1:0] v);
        logic [POS_W-1:0] r;
        if (v[POS_W+1:POS_W-1] == 3'b000 || v[POS_W+1:POS_W-1] == 3'b111) begin
            r = v[POS_W-1:0];
        end else if (v[POS_W+1]) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/plfq_cell.sv =====
// One queue cell holding a particle position and remaining lifetime.
module plfq_cell
    import plfq_pkg::*;
(
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic                  i_load,
    input  logic [LIFE_W-1:0]     i_dt,
    input  logic [2*POS_W-1:0]    i_nb_pos,
    input  logic [LIFE_W-1:0]     i_nb_life,
    input  logic [2*POS_W-1:0]    i_new_pos,
    input  logic [LIFE_W-1:0]     i_new_life,
    output logic [2*POS_W-1:0]    o_pos,
    output logic [LIFE_W-1:0]     o_life
);

    logic [2*POS_W-1:0] r_pos;
    logic [LIFE_W-1:0]  r_life;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            r_pos  <= i_nb_pos;
            r_life <= i_nb_life;
        end else if (i_load) begin
            r_pos  <= i_new_pos;
            r_life <= i_new_life;
        end else if (i_ctl.dec) begin
            r_life <= (r_life > i_dt) ? (r_life - i_dt) : '0;
        end
    end

    assign o_pos  = r_pos;
    assign o_life = r_life;

endmodule

// ===== rtl/plfq_div_stage.sv =====
// One restoring division step of the alpha pipeline, producing one quotient bit.
module plfq_div_stage
    import plfq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [LIFE_W-1:0] i_full,
    input  t_quad             i_q,
    output t_quad             o_q
);

    t_quad             r_q;
    t_quad             n_q;
    logic [LIFE_W:0]   w_part;
    logic [LIFE_W-1:0] w_diff;

    always_comb begin
        w_part = {i_q.rem, i_q.lo[7]};
        w_diff = w_part[LIFE_W-1:0] - i_full;
        n_q    = i_q;
        n_q.lo = {i_q.lo[6:0], 1'b0};
        if (w_part >= {1'b0, i_full}) begin
            n_q.rem = w_diff;
            n_q.q   = {i_q.q[6:0], 1'b1};
        end else begin
            n_q.rem = w_part[LIFE_W-1:0];
            n_q.q   = {i_q.q[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else if (i_adv) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/particle_lifetime_fade_queue.sv =====
// Top level of the particle lifetime fade queue: cell row, control and quad pipeline.
//
// Input items (cmd, pos_x, pos_y, elapsed) arrive on a valid/ready channel and are
// taken only while the block is idle. An add loads the particle into the cell
// after the newest one as the item is taken, or drops it when all DEPTH cells
// are full. A tick pops one expired head particle per cycle and then lowers
// every lifetime. While the receiver does not stall, a draw rotates the cell row
// one place per cycle, once round all DEPTH cells, and feeds the oldest-first
// particles into a quad pipeline of one setup stage and eight division stages,
// one alpha bit each. Each quad passes these stages and the output register before
// it reaches the result ports; quads follow one per cycle while the receiver does
// not stall, and the next item is taken once the rotation is complete.
// The result channel has an output register; while the receiver stalls, the
// whole quad pipeline and the draw rotation hold, and items already delivered
// into the pipeline are never lost. Synchronous reset empties the queue, clears
// the pipeline and restores the configuration defaults.
module particle_lifetime_fade_queue
    import plfq_pkg::*;
#(
    parameter int DEPTH = PLFQ_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_cmd,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic [LIFE_W-1:0]        i_elapsed,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [POS_W-1:0]  o_left,
    output logic signed [POS_W-1:0]  o_top,
    output logic signed [POS_W-1:0]  o_right,
    output logic signed [POS_W-1:0]  o_bottom,
    output logic [RGB_W-1:0]         o_color_out,
    output logic [7:0]               o_alpha,
    output logic                     o_last
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [IW-1:0]       r_rot;
    logic [LIFE_W-1:0]   r_dt;
    logic [LIFE_W-1:0]   r_full_lifetime;
    logic [RGB_W-1:0]    r_particle_rgb;
    logic [SIZE_W-1:0]   r_sprite_width;
    logic [SIZE_W-1:0]   r_sprite_height;
    t_quad               r_front;
    t_quad               n_front;
    t_quad               r_out;

    logic                w_accept;
    logic                w_adv;
    logic                w_pop_ok;
    logic                w_full;
    logic                w_rot_done;
    t_cell_ctl           w_ctl;
    logic [2*POS_W-1:0]  w_pos  [DEPTH];
    logic [LIFE_W-1:0]   w_life [DEPTH];
    t_quad               w_div  [PLFQ_DIV_STEPS+1];

    logic [POS_W+1:0]    w_x;
    logic [POS_W+1:0]    w_y;
    logic [POS_W+1:0]    w_hx;
    logic [POS_W+1:0]    w_hy;
    logic [23:0]         w_prod;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_adv      = !r_out.valid || i_out_ready;
    assign w_pop_ok   = (r_count != '0) && (w_life[0] == '0);
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_rot_done = (r_rot == IW'(DEPTH - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        CMD_TICK: n_state = ST_POP;
                        CMD_DRAW: n_state = ST_DRAW;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_POP: begin
                if (!w_pop_ok) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if (w_adv && w_rot_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_ctl      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_POP: begin
                w_ctl.rot = w_pop_ok;
                w_ctl.dec = !w_pop_ok;
            end
            ST_DRAW: begin
                w_ctl.rot = w_adv;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rot   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_cmd == CMD_ADD && !w_full) begin
                r_count <= r_count + CW'(1);
            end else if (r_state == ST_POP && w_pop_ok) begin
                r_count <= r_count - CW'(1);
            end
            if (w_accept) begin
                r_rot <= '0;
            end else if (r_state == ST_DRAW && w_adv) begin
                r_rot <= r_rot + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt <= i_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_lifetime <= RST_FULL_LIFETIME;
            r_particle_rgb  <= RST_PARTICLE_RGB;
            r_sprite_width  <= RST_SPRITE_SIZE;
            r_sprite_height <= RST_SPRITE_SIZE;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_FULL_LIFETIME: r_full_lifetime <= i_cfg_data[LIFE_W-1:0];
                REG_PARTICLE_RGB:  r_particle_rgb  <= i_cfg_data[RGB_W-1:0];
                REG_SPRITE_WIDTH:  r_sprite_width  <= i_cfg_data[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: r_sprite_height <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int NB = (i + 1) % DEPTH;
        plfq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_load     (w_accept && i_cmd == CMD_ADD && r_count == CW'(i)),
            .i_dt       (r_dt),
            .i_nb_pos   (w_pos[NB]),
            .i_nb_life  (w_life[NB]),
            .i_new_pos  ({i_pos_y, i_pos_x}),
            .i_new_life (r_full_lifetime),
            .o_pos      (w_pos[i]),
            .o_life     (w_life[i])
        );
    end

    always_comb begin
        w_x    = {{2{w_pos[0][POS_W-1]}}, w_pos[0][POS_W-1:0]};
        w_y    = {{2{w_pos[0][2*POS_W-1]}}, w_pos[0][2*POS_W-1:POS_W]};
        w_hx   = {{(POS_W-SIZE_W-1){1'b0}}, r_sprite_width, 3'b000};
        w_hy   = {{(POS_W-SIZE_W-1){1'b0}}, r_sprite_height, 3'b000};
        w_prod = {w_life[0], 8'h00} - {8'h00, w_life[0]};

        n_front        = '0;
        n_front.valid  = (r_state == ST_DRAW) && (CW'(r_rot) < r_count);
        n_front.last   = (CW'(r_rot) + CW'(1)) == r_count;
        n_front.sat    = (r_full_lifetime == '0) || (w_life[0] >= r_full_lifetime);
        n_front.left   = sat20(w_x - w_hx);
        n_front.top    = sat20(w_y - w_hy);
        n_front.right  = sat20(w_x + w_hx);
        n_front.bottom = sat20(w_y + w_hy);
        n_front.rem    = w_prod[23:8];
        n_front.lo     = w_prod[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front.valid <= 1'b0;
        end else if (w_adv) begin
            r_front <= n_front;
        end
    end

    assign w_div[0] = r_front;

    for (genvar s = 0; s < PLFQ_DIV_STEPS; s++) begin : g_div
        plfq_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_full  (r_full_lifetime),
            .i_q     (w_div[s]),
            .o_q     (w_div[s+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_adv) begin
            r_out <= w_div[PLFQ_DIV_STEPS];
        end
    end

    assign o_out_valid = r_out.valid;
    assign o_left      = r_out.left;
    assign o_top       = r_out.top;
    assign o_right     = r_out.right;
    assign o_bottom    = r_out.bottom;
    assign o_color_out = r_particle_rgb;
    assign o_alpha     = r_out.sat ? 8'hFF : r_out.q;
    assign o_last      = r_out.last;

endmodule

// ===== rtl/plfq_checker.sv =====
// Port-level checker for the particle lifetime fade queue and its bind statement.
module plfq_checker
    import plfq_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic [1:0]               i_cmd,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic signed [POS_W-1:0]  o_left,
    input logic signed [POS_W-1:0]  o_top,
    input logic signed [POS_W-1:0]  o_right,
    input logic signed [POS_W-1:0]  o_bottom,
    input logic [7:0]               o_alpha,
    input logic                     o_last
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output item valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left) && $stable(o_alpha)
            && $stable(o_last))
        else $error("Stalled output item changed.");

    a_busy_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_cmd == CMD_TICK || i_cmd == CMD_DRAW) |=> !o_in_ready)
        else $error("Input taken again right after a tick or draw item.");

    a_x_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left <= o_right)
        else $error("Quad left edge lies right of its right edge.");

    a_y_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_top <= o_bottom)
        else $error("Quad top edge lies below its bottom edge.");

endmodule

bind particle_lifetime_fade_queue plfq_checker u_plfq_checker (.*);

// ===== tb/tb_particle_lifetime_fade_queue.sv =====
// Self-checking testbench for the particle lifetime fade queue with a queue predictor.
`timescale 1ns / 1ps

module tb_particle_lifetime_fade_queue;
    import plfq_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [POS_W-1:0] POS_MAX_V = 20'sh7FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN_V = 20'sh80000;
    localparam int EDGE_MAX = (1 << (POS_W - 1)) - 1;
    localparam int EDGE_MIN = -(1 << (POS_W - 1));
    localparam int IDLE_WAIT = 48;
    localparam int unsigned CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic signed [POS_W-1:0] right;
        logic signed [POS_W-1:0] bottom;
        logic [RGB_W-1:0]        color;
        logic [7:0]              alpha;
        logic                    last;
    } t_fade_quad;

    class t_fade_scoreboard;
        logic signed [POS_W-1:0] slot_x [PLFQ_DEPTH];
        logic signed [POS_W-1:0] slot_y [PLFQ_DEPTH];
        logic [LIFE_W-1:0]       slot_life [PLFQ_DEPTH];
        int unsigned             head_slot;
        int unsigned             live_count;
        logic [LIFE_W-1:0]       full_life;
        logic [RGB_W-1:0]        rgb;
        logic [SIZE_W-1:0]       spr_w;
        logic [SIZE_W-1:0]       spr_h;
        t_fade_quad              quad_q [$];
        int errors, quads_checked, n_adds, n_drops, n_ticks, n_pops, n_draws, n_ignored;

        function new();
            head_slot  = 0;
            live_count = 0;
            full_life  = RST_FULL_LIFETIME;
            rgb        = RST_PARTICLE_RGB;
            spr_w      = RST_SPRITE_SIZE;
            spr_h      = RST_SPRITE_SIZE;
        endfunction

        function void set_reg(t_reg idx, logic [CFG_W-1:0] val);
            case (idx)
                REG_FULL_LIFETIME: full_life = val[LIFE_W-1:0];
                REG_PARTICLE_RGB:  rgb = val[RGB_W-1:0];
                REG_SPRITE_WIDTH:  spr_w = val[SIZE_W-1:0];
                REG_SPRITE_HEIGHT: spr_h = val[SIZE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [POS_W-1:0] clamp_edge(int v);
            if (v > EDGE_MAX) v = EDGE_MAX;
            if (v < EDGE_MIN) v = EDGE_MIN;
            return v[POS_W-1:0];
        endfunction

        function void note_input(logic [1:0] cmd, logic signed [POS_W-1:0] x,
                                 logic signed [POS_W-1:0] y, logic [LIFE_W-1:0] dt);
            int unsigned s, k, a;
            int hx, hy, px, py;
            t_fade_quad q;
            case (cmd)
                CMD_ADD: begin
                    n_adds++;
                    if (live_count < PLFQ_DEPTH) begin
                        s = (head_slot + live_count) % PLFQ_DEPTH;
                        slot_x[s] = x;
                        slot_y[s] = y;
                        slot_life[s] = full_life;
                        live_count++;
                    end else begin
                        n_drops++;
                    end
                end
                CMD_TICK: begin
                    n_ticks++;
                    while (live_count > 0 && slot_life[head_slot] == 0) begin
                        head_slot = (head_slot + 1) % PLFQ_DEPTH;
                        live_count--;
                        n_pops++;
                    end
                    for (k = 0; k < live_count; k++) begin
                        s = (head_slot + k) % PLFQ_DEPTH;
                        slot_life[s] = (slot_life[s] > dt) ? slot_life[s] - dt : '0;
                    end
                end
                CMD_DRAW: begin
                    n_draws++;
                    hx = int'(spr_w) * 8;
                    hy = int'(spr_h) * 8;
                    for (k = 0; k < live_count; k++) begin
                        s  = (head_slot + k) % PLFQ_DEPTH;
                        px = int'(slot_x[s]);
                        py = int'(slot_y[s]);
                        if (full_life == 0) begin
                            a = 255;
                        end else begin
                            a = (32'd255 * slot_life[s]) / full_life;
                            if (a > 255) a = 255;
                        end
                        q.left   = clamp_edge(px - hx);
                        q.top    = clamp_edge(py - hy);
                        q.right  = clamp_edge(px + hx);
                        q.bottom = clamp_edge(py + hy);
                        q.color  = rgb;
                        q.alpha  = a[7:0];
                        q.last   = (k + 1 == live_count);
                        quad_q.insert(quad_q.size(), q);
                    end
                end
                default: n_ignored++;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= 30) $display("mismatch at %0t ns: %s", $time, what);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report_mismatch($sformatf("quad %0d field %s: got %0d, expected %0d",
                                          quads_checked, name, got, want));
        endtask

        task check_quad(t_fade_quad got);
            t_fade_quad want;
            if (quad_q.size() == 0) begin
                report_mismatch("quad delivered with none expected");
            end else begin
                want = quad_q[0];
                quad_q.delete(0);
                compare_field("left", int'(got.left), int'(want.left));
                compare_field("top", int'(got.top), int'(want.top));
                compare_field("right", int'(got.right), int'(want.right));
                compare_field("bottom", int'(got.bottom), int'(want.bottom));
                compare_field("color_out", int'(got.color), int'(want.color));
                compare_field("alpha", int'(got.alpha), int'(want.alpha));
                compare_field("last", int'(got.last), int'(want.last));
            end
            quads_checked++;
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_cmd = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic [LIFE_W-1:0]       i_elapsed = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [POS_W-1:0] o_left;
    logic signed [POS_W-1:0] o_top;
    logic signed [POS_W-1:0] o_right;
    logic signed [POS_W-1:0] o_bottom;
    logic [RGB_W-1:0]        o_color_out;
    logic [7:0]              o_alpha;
    logic                    o_last;

    t_fade_scoreboard sb = new();
    int          burst_left = 0;
    int          n_settings = 0;
    int unsigned cycle_cnt = 0;
    int          rx_mode = 0;
    int          rx_hold = 0;

    particle_lifetime_fade_queue DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_cmd(i_cmd),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_elapsed(i_elapsed),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_left(o_left),
        .o_top(o_top),
        .o_right(o_right),
        .o_bottom(o_bottom),
        .o_color_out(o_color_out),
        .o_alpha(o_alpha),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The receiver switches between always ready, coin-flip ready and mostly stalled.
    always @(posedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_hold <= $urandom_range(20, 80);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            default: i_out_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_fade_quad got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.left   = o_left;
            got.top    = o_top;
            got.right  = o_right;
            got.bottom = o_bottom;
            got.color  = o_color_out;
            got.alpha  = o_alpha;
            got.last   = o_last;
            sb.check_quad(got);
        end
    end

    task automatic send_item(logic [1:0] cmd, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic [LIFE_W-1:0] dt);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_elapsed  <= dt;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(cmd, x, y, dt);
    endtask

    task automatic write_regs(logic [LIFE_W-1:0] full, logic [RGB_W-1:0] rgb,
                              logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        t_reg             idx;
        logic [CFG_W-1:0] val;
        for (int r = 0; r < 4; r++) begin
            idx = t_reg'(r);
            case (idx)
                REG_FULL_LIFETIME: val = CFG_W'(full);
                REG_PARTICLE_RGB:  val = CFG_W'(rgb);
                REG_SPRITE_WIDTH:  val = CFG_W'(w);
                default:           val = CFG_W'(h);
            endcase
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            sb.set_reg(idx, val);
        end
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Adds and ticks leave no result behind, so the block gets time to finish them.
    task automatic drain_queue();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (sb.quad_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return POS_MAX_V - POS_W'($urandom_range(0, 200));
            1: return POS_MIN_V + POS_W'($urandom_range(0, 200));
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic logic [LIFE_W-1:0] rand_elapsed();
        if ($urandom_range(0, 9) < 3) return LIFE_W'($urandom);
        return LIFE_W'($urandom_range(0, int'(sb.full_life) / 3 + 2));
    endfunction

    task automatic random_config(int phase);
        logic [LIFE_W-1:0] full;
        logic [RGB_W-1:0]  rgb;
        logic [SIZE_W-1:0] sz [2];
        case ($urandom_range(0, 5))
            0: full = 16'd1;
            1: full = 16'hFFFF;
            2: full = LIFE_W'($urandom_range(1, 16));
            3: full = '0;
            default: full = LIFE_W'($urandom_range(1, 65535));
        endcase
        if (phase == 0) full = 16'hFFFF;
        case ($urandom_range(0, 3))
            0: rgb = '0;
            1: rgb = '1;
            default: rgb = RGB_W'($urandom);
        endcase
        for (int k = 0; k < 2; k++) begin
            case ($urandom_range(0, 3))
                0: sz[k] = '0;
                1: sz[k] = '1;
                default: sz[k] = SIZE_W'($urandom);
            endcase
        end
        write_regs(full, rgb, sz[0], sz[1]);
    endtask

    task automatic run_random_phase(int n_items, int add_pct, bit fill_first);
        logic [1:0] cmd;
        int         r;
        if (fill_first) begin
            for (int k = 0; k < PLFQ_DEPTH + 2; k++)
                send_item(CMD_ADD, rand_pos(), rand_pos(), rand_elapsed());
        end
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) cmd = CMD_ADD;
            else if (r < add_pct + (100 - add_pct) / 2) cmd = CMD_TICK;
            else if (r < 95) cmd = CMD_DRAW;
            else cmd = CMD_UNUSED;
            send_item(cmd, rand_pos(), rand_pos(), rand_elapsed());
        end
    endtask

    initial begin
        int add_mix [4] = '{30, 45, 60, 70};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: empty draw, ignored code, corners that saturate, fading.
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_UNUSED, POS_MAX_V, POS_MIN_V, 16'hFFFF);
        send_item(CMD_ADD, POS_MAX_V, POS_MAX_V, 0);
        send_item(CMD_ADD, POS_MIN_V, POS_MIN_V, 0);
        send_item(CMD_ADD, 0, 0, 16'hFFFF);
        send_item(CMD_ADD, POS_MIN_V, POS_MAX_V, 0);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 300);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 16'hFFFF);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 1);
        send_item(CMD_DRAW, 0, 0, 0);
        drain_queue();

        // A zero full lifetime gives full opacity and lets the next tick pop everything.
        write_regs(0, 0, 10'd1023, 0);
        send_item(CMD_ADD, 1, -1, 0);
        send_item(CMD_ADD, POS_MAX_V, POS_MIN_V, 0);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 5);
        send_item(CMD_DRAW, 0, 0, 0);
        drain_queue();

        // Lowering the full lifetime below what particles hold saturates alpha.
        write_regs(16'd600, 24'hFFFFFF, 0, 10'd1023);
        repeat (3) send_item(CMD_ADD, rand_pos(), rand_pos(), 0);
        drain_queue();
        write_regs(16'd1, 24'hA5A5A5, 0, 10'd1023);
        send_item(CMD_DRAW, 0, 0, 0);
        send_item(CMD_TICK, 0, 0, 1);
        send_item(CMD_DRAW, 0, 0, 0);
        drain_queue();

        for (int p = 0; p < 8; p++) begin
            random_config(p);
            run_random_phase(12, add_mix[p % 4], (p % 4) == 0);
            drain_queue();
        end

        $display("Covered %0d adds (%0d dropped when full), %0d ticks popping %0d particles,",
                 sb.n_adds, sb.n_drops, sb.n_ticks, sb.n_pops);
        $display("%0d draws, %0d ignored items, %0d quads checked over %0d register settings.",
                 sb.n_draws, sb.n_ignored, sb.quads_checked, n_settings);
        if (sb.errors == 0 && sb.quad_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
